### design/prime_sieve_next_prime_gap_assert.svh
// Assertion macros for the prime gap lookup block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef PRIME_SIEVE_NEXT_PRIME_GAP_ASSERT_SVH
`define PRIME_SIEVE_NEXT_PRIME_GAP_ASSERT_SVH

// same-cycle implication
`define PSG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psg assertion failed");

// next-cycle implication
`define PSG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psg assertion failed");

`endif

### design/psg_pkg.sv
// Package for the prime gap lookup block: widths, limits and shared types.
// No dependencies.
`default_nettype none
package psg_pkg;
	localparam int VALUE_W  = 20;
	localparam int GAP_W    = 8;
	localparam int LOG_WORD = 6;
	localparam int WORD_W   = 1 << LOG_WORD;
	localparam int GAP_MAX  = 255;
	localparam int SCAN_WORDS = 5;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic             found;
		logic [GAP_W-1:0] gap;
	} eval_t;
endpackage
`default_nettype wire

### design/prime_sieve_next_prime_gap.sv
// Prime gap lookup: top level with the sieve and query sequencer.
// Depends on psg_pkg, psg_ram, psg_eval and prime_sieve_next_prime_gap_assert.svh.
//
// Usage:
//  A query is taken when start is high and busy is low; value is sampled then.
//  One result follows per query: valid is high for one cycle with gap and
//  no_prime. The receiver cannot stall; results are simply presented.
//  After reset busy stays high while the bitmap is built: the memory is filled
//  word by word, then the sieve clears each multiple with a read and a write,
//  then a short downward scan for the highest word holding a prime.
//  A query that is out of the table or above the highest prime word answers
//  in the cycle after it is taken, and busy stays low. Otherwise the memory is
//  read one 64-bit word per cycle from the query's word on, up to five words,
//  and valid comes when the scan ends; busy drops with it.
//  A new query may be issued in the cycle valid is high.
`default_nettype none
module prime_sieve_next_prime_gap #(
	parameter int TABLE_BITS = 20
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [psg_pkg::VALUE_W-1:0]  value,
	output logic                              valid,
	output logic [psg_pkg::GAP_W-1:0]         gap,
	output logic                              no_prime
);
	import psg_pkg::*;

	localparam int AW    = TABLE_BITS - LOG_WORD;
	localparam int IW    = (TABLE_BITS + 1) / 2 + 1;
	localparam int SQ_W  = 2 * IW;
	localparam int J_W   = TABLE_BITS + 1;

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_ORD  = 4'd1;
	localparam logic [3:0] S_OCHK = 4'd2;
	localparam logic [3:0] S_MRD  = 4'd3;
	localparam logic [3:0] S_MWR  = 4'd4;
	localparam logic [3:0] S_TRD  = 4'd5;
	localparam logic [3:0] S_TCHK = 4'd6;
	localparam logic [3:0] S_IDLE = 4'd7;
	localparam logic [3:0] S_QDAT = 4'd8;

	logic [3:0]            state_q;
	logic [AW-1:0]         cnt_q;
	logic [IW-1:0]         i_q;
	logic [J_W-1:0]        j_q;
	logic [AW-1:0]         top_q;
	logic [AW-1:0]         qaddr_q;
	logic [2:0]            k_q;
	logic [LOG_WORD-1:0]   vlo_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	word_t                 wdata;
	logic [AW-1:0]         raddr;
	word_t                 rdata;
	eval_t                 ev;

	logic [TABLE_BITS-1:0] i_ext;
	logic [SQ_W-1:0]       sq;
	logic                  sq_over;
	logic [J_W-1:0]        j_next;
	logic [TABLE_BITS-1:0] vt;
	logic [AW-1:0]         w0;
	logic                  out_rng;
	logic                  accept;

	assign i_ext   = TABLE_BITS'(i_q);
	assign sq      = SQ_W'(i_q) * SQ_W'(i_q);
	assign sq_over = |sq[SQ_W-1:TABLE_BITS];
	assign j_next  = j_q + J_W'(i_q);
	assign vt      = TABLE_BITS'(value);
	assign w0      = vt[TABLE_BITS-1:LOG_WORD];
	assign out_rng = (value >> TABLE_BITS) != '0;
	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;

	always_comb begin
		we    = 1'b0;
		waddr = j_q[TABLE_BITS-1:LOG_WORD];
		wdata = rdata & ~(word_t'(1) << j_q[LOG_WORD-1:0]);
		raddr = w0;
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = (cnt_q == '0) ? {{(WORD_W-2){1'b1}}, 2'b00} : {WORD_W{1'b1}};
			end
			S_ORD:   raddr = i_ext[TABLE_BITS-1:LOG_WORD];
			S_MRD:   raddr = j_q[TABLE_BITS-1:LOG_WORD];
			S_MWR:   we = 1'b1;
			S_TRD:   raddr = top_q;
			S_QDAT:  raddr = qaddr_q + AW'(1);
			default: raddr = w0;
		endcase
	end

	psg_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	psg_eval u_eval (
		.word (rdata),
		.k    (k_q),
		.vlo  (vlo_q),
		.res  (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
			i_q     <= IW'(2);
			j_q     <= '0;
			top_q   <= '1;
			valid   <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == '1) begin
						state_q <= S_ORD;
					end
				end
				S_ORD: begin
					state_q <= sq_over ? S_TRD : S_OCHK;
				end
				S_OCHK: begin
					if (rdata[i_ext[LOG_WORD-1:0]]) begin
						j_q     <= sq[J_W-1:0];
						state_q <= S_MRD;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_ORD;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (j_next[TABLE_BITS]) begin
						i_q     <= i_q + IW'(1);
						state_q <= S_ORD;
					end else begin
						j_q     <= j_next;
						state_q <= S_MRD;
					end
				end
				S_TRD: begin
					state_q <= S_TCHK;
				end
				S_TCHK: begin
					if (rdata != '0) begin
						state_q <= S_IDLE;
					end else begin
						top_q   <= top_q - AW'(1);
						state_q <= S_TRD;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (out_rng || (w0 > top_q)) begin
							valid <= 1'b1;
						end else begin
							state_q <= S_QDAT;
						end
					end
				end
				S_QDAT: begin
					if (ev.found || (qaddr_q == top_q) ||
						(k_q == 3'(SCAN_WORDS - 1))) begin
						valid   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					qaddr_q  <= w0;
					k_q      <= 3'd0;
					vlo_q    <= vt[LOG_WORD-1:0];
					gap      <= '0;
					no_prime <= 1'b1;
				end
			end
			S_QDAT: begin
				qaddr_q <= qaddr_q + AW'(1);
				k_q     <= k_q + 3'd1;
				if (ev.found) begin
					gap      <= ev.gap;
					no_prime <= 1'b0;
				end else if (qaddr_q == top_q) begin
					gap      <= '0;
					no_prime <= 1'b1;
				end else begin
					gap      <= GAP_W'(GAP_MAX);
					no_prime <= 1'b0;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

`include "prime_sieve_next_prime_gap_assert.svh"

	`PSG_ASSERT_NOW(a_valid_idle, valid, !busy)
	`PSG_ASSERT_NOW(a_none_zero_gap, valid && no_prime, gap == '0)
	`PSG_ASSERT_NEXT(a_accept_answers, accept, valid || (state_q == S_QDAT))
	`PSG_ASSERT_NOW(a_scan_bound, state_q == S_QDAT, k_q < 3'(SCAN_WORDS))

endmodule
`default_nettype wire

### design/psg_ram.sv
// Bitmap memory: one write port, one read port, registered read data.
// Depends on psg_pkg.
`default_nettype none
module psg_ram #(
	parameter int AW = 14
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire psg_pkg::word_t  wdata,
	input  wire logic [AW-1:0]   raddr,
	output psg_pkg::word_t       rdata
);
	import psg_pkg::*;

	word_t mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### design/psg_eval.sv
// Query word evaluation: first set bit at or above the query bit, and its gap.
// Depends on psg_pkg.
`default_nettype none
module psg_eval (
	input  wire psg_pkg::word_t        word,
	input  wire logic [2:0]            k,
	input  wire logic [psg_pkg::LOG_WORD-1:0] vlo,
	output psg_pkg::eval_t             res
);
	import psg_pkg::*;

	word_t                 masked;
	logic [7:0]            byte_nz;
	logic [2:0]            bsel;
	logic [7:0]            sel_byte;
	logic [2:0]            bpos;
	logic [LOG_WORD-1:0]   pos;
	logic [9:0]            span;

	always_comb begin
		masked = (k == 3'd0) ? (word & ({WORD_W{1'b1}} << vlo)) : word;
		for (int b = 0; b < 8; b++) begin
			byte_nz[b] = |masked[b*8 +: 8];
		end
		bsel = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (byte_nz[b]) begin
				bsel = 3'(b);
			end
		end
		sel_byte = masked[bsel*8 +: 8];
		bpos = 3'd0;
		for (int t = 7; t >= 0; t--) begin
			if (sel_byte[t]) begin
				bpos = 3'(t);
			end
		end
		pos = {bsel, bpos};
		span = {1'b0, k, pos} - {4'd0, vlo};
		res.found = |byte_nz;
		res.gap = (span > 10'(GAP_MAX)) ? GAP_W'(GAP_MAX) : span[GAP_W-1:0];
	end
endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench for prime_sieve_next_prime_gap: random and directed gap queries.
// Depends on psg_pkg and the block; builds its own sieve to predict each gap.
`default_nettype none
module tb_top;
	import psg_pkg::*;

	// full table; the sieve runs after reset
	localparam int TBL_BITS = 20;
	localparam int TBL_SIZE = 1 << TBL_BITS;
	localparam int N_RANDOM = 800;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [GAP_W-1:0]   gap;
		logic               no_prime;
	} gap_answer_t;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic [VALUE_W-1:0] value  = '0;
	logic               busy;
	logic               valid;
	logic [GAP_W-1:0]   gap;
	logic               no_prime;

	bit                 is_prime [TBL_SIZE];
	int                 top_prime;
	logic [VALUE_W-1:0] query_q [$];
	gap_answer_t        answer_q [$];
	int                 bad_cnt    = 0;
	int                 idle_left  = 0;
	int                 burst_left = 0;

	prime_sieve_next_prime_gap #(.TABLE_BITS(TBL_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.valid    (valid),
		.gap      (gap),
		.no_prime (no_prime)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void build_sieve();
		int i;
		int j;
		for (i = 0; i < TBL_SIZE; i++)
			is_prime[i] = 1'b1;
		is_prime[0] = 1'b0;
		is_prime[1] = 1'b0;
		for (i = 2; i * i < TBL_SIZE; i++)
			if (is_prime[i])
				for (j = i * i; j < TBL_SIZE; j += i)
					is_prime[j] = 1'b0;
		top_prime = 0;
		for (i = TBL_SIZE - 1; i > 0 && top_prime == 0; i--)
			if (is_prime[i])
				top_prime = i;
	endfunction

	function automatic gap_answer_t predict_gap(input logic [VALUE_W-1:0] v);
		gap_answer_t a;
		int          vi;
		int          d;
		bit          hit;
		vi         = int'(v);
		a.value    = v;
		a.gap      = GAP_W'(GAP_MAX);
		a.no_prime = 1'b0;
		hit        = 1'b0;
		if (vi >= TBL_SIZE || vi > top_prime) begin
			a.gap      = '0;
			a.no_prime = 1'b1;
		end else begin
			for (d = 0; d < GAP_MAX && !hit; d++)
				if (vi + d < TBL_SIZE && is_prime[vi + d]) begin
					a.gap = GAP_W'(d);
					hit   = 1'b1;
				end
		end
		return a;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function int idle_len();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin : drive
		logic fire;
		logic next_start;
		fire       = start && !busy;
		next_start = 1'b0;
		if (arst_n) begin
			if (fire)
				answer_q.insert(answer_q.size(), predict_gap(value));
			if (start && !fire) begin
				next_start = 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
				value <= VALUE_W'($urandom);
			end else if (query_q.size() > 0) begin
				next_start = 1'b1;
				value      <= query_q.pop_front();
				idle_left  = idle_len();
			end
		end
		start <= next_start;
	end

	always @(posedge clk) begin : check
		gap_answer_t want;
		if (arst_n && valid) begin
			if (answer_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("unexpected result: gap=%0d no_prime=%0b", gap, no_prime);
			end else begin
				want = answer_q.pop_front();
				if (gap !== want.gap || no_prime !== want.no_prime) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("value %0d: expected gap=%0d no_prime=%0b, got gap=%0d no_prime=%0b",
							want.value, want.gap, want.no_prime, gap, no_prime);
				end
			end
		end
	end

	initial begin : stim
		int directed [$];
		int i;
		int r;
		int v;
		int drain;
		build_sieve();
		directed = '{0, 1, 2, 3, 4, 8, 9, 24, 89, 90, 31397, 31398, 31469,
			top_prime - 1, top_prime, top_prime + 1, TBL_SIZE - 1, TBL_SIZE,
			TBL_SIZE + 1, 20'hFFFFF, 20'h80000, 20'h55555, 20'hAAAAA};
		foreach (directed[k])
			query_q.insert(query_q.size(), directed[k][VALUE_W-1:0]);
		for (i = 0; i < N_RANDOM; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				v = $urandom_range(0, TBL_SIZE - 1);
			else if (r < 72)
				v = $urandom_range(0, 400);
			else if (r < 84)
				v = $urandom_range(top_prime - 300, top_prime + 300);
			else if (r < 94)
				v = $urandom;
			else
				v = $urandom_range(TBL_SIZE - 8, TBL_SIZE + 8);
			query_q.insert(query_q.size(), v[VALUE_W-1:0]);
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (query_q.size() > 0 || start)
			@(posedge clk);
		drain = 0;
		while (answer_q.size() > 0 && drain < 1000) begin
			@(posedge clk);
			drain++;
		end
		repeat (12) @(posedge clk);
		if (answer_q.size() > 0) begin
			bad_cnt++;
			$display("%0d results never arrived", answer_q.size());
		end
		if (bad_cnt == 0)
			$display("PASS prime_sieve_next_prime_gap");
		else
			$display("FAIL prime_sieve_next_prime_gap");
		$finish;
	end

	initial begin : watchdog
		#200_000_000;
		$display("timeout");
		$display("FAIL prime_sieve_next_prime_gap");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
+incdir+design
design/psg_pkg.sv
design/psg_ram.sv
design/psg_eval.sv
design/prime_sieve_next_prime_gap.sv
verif/tb_top.sv
